[src/bpe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bpe_pkg;

    localparam int MAX_POINTS  = 8;
    localparam int COORD_BITS  = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int IDX_BITS    = 3;
    localparam int CNT_BITS    = 4;
    localparam int T_BITS      = T_FRAC_BITS + 1;
    localparam int PT_BITS     = 2 * COORD_BITS;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + T_BITS + 1;

    localparam logic [T_BITS-1:0]   T_ONE       = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [CNT_BITS-1:0] COUNT_RESET = CNT_BITS'(4);
    localparam logic [CNT_BITS-1:0] COUNT_MAX   = CNT_BITS'(MAX_POINTS);

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[src/bpe_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpe_cfg_if
    import bpe_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [CNT_BITS-1:0] point_count;

    modport source (output valid, output point_count, input ready);
    modport sink   (input valid, input point_count, output ready);
endinterface

`default_nettype wire

[src/bpe_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpe_in_if
    import bpe_pkg::*;
;
    logic                         valid;
    logic                         ready;
    t_action                      action;
    logic        [IDX_BITS-1:0]   point_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
    logic        [T_BITS-1:0]     position_t;

    modport source (output valid, output action, output point_index, output coord_x,
                    output coord_y, output position_t, input ready);
    modport sink   (input valid, input action, input point_index, input coord_x,
                    input coord_y, input position_t, output ready);
endinterface

`default_nettype wire

[src/bpe_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface bpe_out_if
    import bpe_pkg::*;
;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

[src/bezier_point_evaluator_unit.sv]
// Bezier point evaluator: de Casteljau evaluation of a 2-D curve of up to
// eight control points, with signed 16-bit coordinates and t in unsigned Q1.16.
// Channels: i_cfg writes point_count; i_item takes one transaction per item;
// o_result returns exactly one transaction per item, in order.
// A load (action 0) writes one control point and echoes its coordinates;
// it passes through S_DONE on its way to the output register.
// An evaluation (action 1) with L lerp levels, L = point_count - 1 and at
// most seven, runs each level as one pass: the first reads the control
// memory, later ones the scratch memory, one read per point of the level,
// then S_DRAIN waits while the last lerp writes back. Its run is set by the
// single shared lerp unit and the one read port of each memory; a
// point_count of one or less copies point 0.
// One item is in work at a time; i_item.ready is high while the engine is
// idle, also while a finished result waits in the output register.
// When the receiver stalls, the next result holds in the engine until the
// output register frees, and no new item is taken meanwhile.
// Reset (synchronous, active low) clears all control points to zero through
// per-entry valid bits, sets point_count to 4 and empties the output.
// i_cfg is always ready; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module bezier_point_evaluator_unit
    import bpe_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bpe_cfg_if.sink    i_cfg,
    bpe_in_if.sink     i_item,
    bpe_out_if.source  o_result
);

    t_state r_state, n_state;

    logic [CNT_BITS-1:0]   r_point_count;
    logic [MAX_POINTS-1:0] r_pt_valid;
    logic [IDX_BITS-1:0]   r_level, n_level;
    logic [IDX_BITS-1:0]   r_rd_idx, n_rd_idx;
    logic                  r_first, n_first;
    logic                  r_drain, n_drain;
    logic [T_BITS-1:0]     r_t;

    logic                  in_accept;
    logic                  load_we;
    logic                  eval_start;
    logic                  rd_en;
    logic                  out_load;
    logic [IDX_BITS-1:0]   start_level;
    logic [T_BITS-1:0]     t_sat;

    logic [PT_BITS-1:0]    ctrl_rdata;
    logic [PT_BITS-1:0]    scr_rdata;
    logic [PT_BITS-1:0]    cur;

    logic                  r_s1_v;
    logic [IDX_BITS-1:0]   r_s1_k;
    logic                  r_s1_ctrl;
    logic                  r_s1_mask;
    logic                  r_s1_copy;
    logic                  r_s1_final;

    logic                  r_s2_v;
    logic [IDX_BITS-1:0]   r_s2_k;
    logic                  r_s2_final;
    logic signed [COORD_BITS-1:0] r_s2_ax, r_s2_ay;
    logic signed [PROD_BITS-1:0]  r_s2_px, r_s2_py;

    logic [PT_BITS-1:0]    r_prev;
    logic [PT_BITS-1:0]    r_res;

    logic signed [COORD_BITS-1:0] cur_x, cur_y, prev_x, prev_y;
    logic signed [DIFF_BITS-1:0]  diff_x, diff_y;
    logic signed [T_BITS:0]       t_s;
    logic signed [PROD_BITS-1:0]  prod_x, prod_y;
    logic signed [PROD_BITS-1:0]  sum_x, sum_y;
    logic [PT_BITS-1:0]           lerp_res;

    logic                         r_out_v;
    logic signed [COORD_BITS-1:0] r_out_x, r_out_y;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);
    assign in_accept    = i_item.valid && i_item.ready;

    always_comb begin
        if (r_point_count >= COUNT_MAX) begin
            start_level = IDX_BITS'(MAX_POINTS - 1);
        end else if (r_point_count == '0) begin
            start_level = '0;
        end else begin
            start_level = IDX_BITS'(r_point_count - CNT_BITS'(1));
        end
        t_sat = (i_item.position_t > T_ONE) ? T_ONE : i_item.position_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_level    = r_level;
        n_rd_idx   = r_rd_idx;
        n_first    = r_first;
        n_drain    = r_drain;
        load_we    = 1'b0;
        eval_start = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (i_item.action == ACT_LOAD) begin
                        load_we = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        eval_start = 1'b1;
                        n_level    = start_level;
                        n_rd_idx   = '0;
                        n_first    = 1'b1;
                        n_state    = S_READ;
                    end
                end
            end
            S_READ: begin
                rd_en = 1'b1;
                if (r_rd_idx == r_level) begin
                    n_drain = 1'b1;
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + IDX_BITS'(1);
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_drain = 1'b0;
                end else if (r_level <= IDX_BITS'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_level  = r_level - IDX_BITS'(1);
                    n_rd_idx = '0;
                    n_first  = 1'b0;
                    n_state  = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_v || o_result.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_level  <= n_level;
        r_rd_idx <= n_rd_idx;
        r_first  <= n_first;
        if (eval_start) begin
            r_t <= t_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= COUNT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_point_count <= i_cfg.point_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_valid <= '0;
        end else if (load_we) begin
            r_pt_valid[i_item.point_index] <= 1'b1;
        end
    end

    bpe_ram #(
        .WIDTH (PT_BITS),
        .DEPTH (MAX_POINTS)
    ) u_ctrl_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (i_item.point_index),
        .i_wdata ({i_item.coord_x, i_item.coord_y}),
        .i_re    (rd_en && r_first),
        .i_raddr (r_rd_idx),
        .o_rdata (ctrl_rdata)
    );

    bpe_ram #(
        .WIDTH (PT_BITS),
        .DEPTH (MAX_POINTS)
    ) u_scr_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_v),
        .i_waddr (r_s2_k),
        .i_wdata (lerp_res),
        .i_re    (rd_en && !r_first),
        .i_raddr (r_rd_idx),
        .o_rdata (scr_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= rd_en;
            r_s2_v <= r_s1_v && !r_s1_copy && (r_s1_k != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_k     <= r_rd_idx;
        r_s1_ctrl  <= r_first;
        r_s1_mask  <= r_pt_valid[r_rd_idx];
        r_s1_copy  <= (r_level == '0);
        r_s1_final <= (r_level == IDX_BITS'(1));
    end

    always_comb begin
        if (r_s1_ctrl) begin
            cur = r_s1_mask ? ctrl_rdata : '0;
        end else begin
            cur = scr_rdata;
        end
        cur_x  = cur[PT_BITS-1:COORD_BITS];
        cur_y  = cur[COORD_BITS-1:0];
        prev_x = r_prev[PT_BITS-1:COORD_BITS];
        prev_y = r_prev[COORD_BITS-1:0];
        diff_x = DIFF_BITS'(cur_x) - DIFF_BITS'(prev_x);
        diff_y = DIFF_BITS'(cur_y) - DIFF_BITS'(prev_y);
        t_s    = $signed({1'b0, r_t});
        prod_x = PROD_BITS'(diff_x) * PROD_BITS'(t_s);
        prod_y = PROD_BITS'(diff_y) * PROD_BITS'(t_s);
        sum_x  = PROD_BITS'(r_s2_ax) + (r_s2_px >>> T_FRAC_BITS);
        sum_y  = PROD_BITS'(r_s2_ay) + (r_s2_py >>> T_FRAC_BITS);
        lerp_res = {sum_x[COORD_BITS-1:0], sum_y[COORD_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v) begin
            r_prev     <= cur;
            r_s2_k     <= r_s1_k - IDX_BITS'(1);
            r_s2_final <= r_s1_final;
            r_s2_ax    <= prev_x;
            r_s2_ay    <= prev_y;
            r_s2_px    <= prod_x;
            r_s2_py    <= prod_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            r_res <= {i_item.coord_x, i_item.coord_y};
        end else if (r_s1_v && r_s1_copy) begin
            r_res <= cur;
        end else if (r_s2_v && r_s2_final) begin
            r_res <= lerp_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_load) begin
            r_out_v <= 1'b1;
        end else if (o_result.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_x <= r_res[PT_BITS-1:COORD_BITS];
            r_out_y <= r_res[COORD_BITS-1:0];
        end
    end

    assign o_result.valid   = r_out_v;
    assign o_result.point_x = r_out_x;
    assign o_result.point_y = r_out_y;

`ifndef NO_ASSERTIONS
    a_rd_in_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rd_idx <= r_level))
        else $error("read index beyond current level");

    a_wb_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == S_READ || r_state == S_DRAIN))
        else $error("lerp write-back outside an evaluation pass");

    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_s1_v && !r_s2_v))
        else $error("result presented with lerp pipeline still busy");

    a_read_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_DRAIN && r_state == S_READ) |-> !r_s2_v)
        else $error("next level starts before previous write-back completed");
`endif

endmodule

`default_nettype wire

[src/bpe_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[bench/tb_bezier_point_evaluator_unit.sv]
`timescale 1ns / 1ps

module tb_bezier_point_evaluator_unit;
    import bpe_pkg::*;

    localparam int ITEMS_PER_PHASE = 120;
    localparam int PHASES          = 14;
    localparam int MAX_GAP         = 18;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } t_coord_pair;

    class curve_predictor;
        logic signed [COORD_BITS-1:0] store_x [MAX_POINTS];
        logic signed [COORD_BITS-1:0] store_y [MAX_POINTS];
        logic        [CNT_BITS-1:0]   point_count;
        t_coord_pair                  pending_points [$];
        int                           mismatches;

        function new();
            foreach (store_x[i]) begin
                store_x[i] = '0;
                store_y[i] = '0;
            end
            point_count = COUNT_RESET;
            mismatches  = 0;
        endfunction

        function void set_count(logic [CNT_BITS-1:0] value);
            point_count = value;
        endfunction

        function int pending();
            return pending_points.size();
        endfunction

        function longint lerp(longint a, longint b, logic [T_BITS-1:0] t);
            longint prod;
            prod = (b - a) * longint'(t);
            return a + (prod >>> T_FRAC_BITS);
        endfunction

        function t_coord_pair casteljau(logic [T_BITS-1:0] t_in);
            longint            wx [MAX_POINTS];
            longint            wy [MAX_POINTS];
            logic [T_BITS-1:0] t;
            int                n;
            t_coord_pair       p;
            t = (t_in > T_ONE) ? T_ONE : t_in;
            n = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
            if (n < 1) begin
                n = 1;
            end
            foreach (wx[i]) begin
                wx[i] = store_x[i];
                wy[i] = store_y[i];
            end
            for (int lvl = n - 1; lvl > 0; lvl--) begin
                for (int k = 0; k < lvl; k++) begin
                    wx[k] = lerp(wx[k], wx[k + 1], t);
                    wy[k] = lerp(wy[k], wy[k + 1], t);
                end
            end
            p.x = COORD_BITS'(wx[0]);
            p.y = COORD_BITS'(wy[0]);
            return p;
        endfunction

        function void take_item(t_action act, logic [IDX_BITS-1:0] idx,
                                logic signed [COORD_BITS-1:0] x,
                                logic signed [COORD_BITS-1:0] y,
                                logic [T_BITS-1:0] t);
            t_coord_pair p;
            if (act == ACT_LOAD) begin
                if (idx < MAX_POINTS) begin
                    store_x[idx] = x;
                    store_y[idx] = y;
                end
                p.x = x;
                p.y = y;
            end else begin
                p = casteljau(t);
            end
            pending_points.insert(pending_points.size(), p);
        endfunction

        function void match_result(logic signed [COORD_BITS-1:0] x,
                                   logic signed [COORD_BITS-1:0] y);
            t_coord_pair want;
            if (pending_points.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result transaction x=%0d y=%0d", $time, x, y);
                return;
            end
            want = pending_points.pop_front();
            if (want.x !== x) begin
                mismatches++;
                $display("%0t: point_x expected %0d, got %0d", $time, want.x, x);
            end
            if (want.y !== y) begin
                mismatches++;
                $display("%0t: point_y expected %0d, got %0d", $time, want.y, y);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   tx_burst = 1'b0;
    bit   rx_burst = 1'b0;

    curve_predictor curve;

    bpe_cfg_if cfg_bus ();
    bpe_in_if  item_bus ();
    bpe_out_if result_bus ();

    bezier_point_evaluator_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (item_bus),
        .o_result (result_bus)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n && result_bus.valid && result_bus.ready) begin
            curve.match_result(result_bus.point_x, result_bus.point_y);
        end
    end

    initial begin
        int gap;
        result_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                @(negedge clk) result_bus.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk) result_bus.ready <= 1'b1;
            do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
        end
    end

    function automatic logic signed [COORD_BITS-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(COORD_BITS - 1){1'b0}}};
            1:       return {1'b0, {(COORD_BITS - 1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic send_item(t_action act, logic [IDX_BITS-1:0] idx,
                             logic signed [COORD_BITS-1:0] x,
                             logic signed [COORD_BITS-1:0] y,
                             logic [T_BITS-1:0] t);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            @(negedge clk) item_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_bus.valid       <= 1'b1;
        item_bus.action      <= act;
        item_bus.point_index <= idx;
        item_bus.coord_x     <= x;
        item_bus.coord_y     <= y;
        item_bus.position_t  <= t;
        do @(posedge clk); while (!(item_bus.valid && item_bus.ready));
        curve.take_item(act, idx, x, y, t);
    endtask

    task automatic send_random_item();
        logic [T_BITS-1:0] t;
        case ($urandom_range(0, 9))
            0:       t = '0;
            1:       t = T_ONE;
            2:       t = T_BITS'($urandom_range(int'(T_ONE) + 1, (1 << T_BITS) - 1));
            3:       t = T_ONE - 1;
            default: t = T_BITS'($urandom_range(0, int'(T_ONE)));
        endcase
        send_item(t_action'($urandom_range(0, 1)), IDX_BITS'($urandom_range(0, 7)),
                  pick_coord(), pick_coord(), t);
    endtask

    task automatic hold_item_idle();
        @(negedge clk) item_bus.valid <= 1'b0;
    endtask

    task automatic write_count(logic [CNT_BITS-1:0] value);
        @(negedge clk);
        cfg_bus.valid       <= 1'b1;
        cfg_bus.point_count <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        curve.set_count(value);
        @(negedge clk) cfg_bus.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (curve.pending() > 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        int seed_x [MAX_POINTS];
        int seed_y [MAX_POINTS];
        int seed_t [7];
        int phase_counts [PHASES - 1];
        int count;

        seed_x       = '{-32768, 32767, 32767, -32768, 21845, -1, 0, 1234};
        seed_y       = '{32767, -32768, 32767, -32768, -21846, 0, -1, -4321};
        seed_t       = '{0, 1, 32768, 65535, 65536, 65537, 131071};
        phase_counts = '{8, 2, 0, 1, 15, 9, 3, 5, 6, 7, 4, 8, 2};

        cfg_bus.valid        = 1'b0;
        cfg_bus.point_count  = '0;
        item_bus.valid       = 1'b0;
        item_bus.action      = ACT_LOAD;
        item_bus.point_index = '0;
        item_bus.coord_x     = '0;
        item_bus.coord_y     = '0;
        item_bus.position_t  = '0;
        rst_n                = 1'b0;
        curve                = new();

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        send_item(ACT_EVAL, '0, '0, '0, T_ONE >> 1);
        for (int i = 0; i < MAX_POINTS; i++) begin
            send_item(ACT_LOAD, IDX_BITS'(i), COORD_BITS'(seed_x[i]),
                      COORD_BITS'(seed_y[i]), '0);
        end
        foreach (seed_t[i]) begin
            send_item(ACT_EVAL, '0, '0, '0, T_BITS'(seed_t[i]));
        end
        hold_item_idle();

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            count = (p < PHASES - 1) ? phase_counts[p] : $urandom_range(0, 15);
            write_count(CNT_BITS'(count));
            tx_burst = ($urandom_range(0, 2) == 0);
            rx_burst = ($urandom_range(0, 2) == 0);
            repeat (ITEMS_PER_PHASE) send_random_item();
            hold_item_idle();
        end

        wait_drained();
        repeat (64) @(posedge clk);
        if (curve.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
src/bpe_pkg.sv
src/bpe_cfg_if.sv
src/bpe_in_if.sv
src/bpe_out_if.sv
src/bpe_ram.sv
src/bezier_point_evaluator_unit.sv
bench/tb_bezier_point_evaluator_unit.sv
